// ===== hdl/lfpid_pkg.sv =====
// Package: shared types, constants and the line-position table.
`timescale 1ns / 1ps
package lfpid_pkg;

   localparam int SPEED_LIMIT_DEF = 250;
   localparam int SAMPLE_BITS_DEF = 10;
   localparam int NUM_SENSORS     = 5;
   localparam int CSR_IDX_W       = 3;
   localparam int QUEUE_DEPTH     = 2;

   localparam int ERR_W  = 14;
   localparam int DT_W   = 10;
   localparam int ACC_W  = 29;
   localparam int GAIN_W = 16;

   localparam logic [63:0] THR_RESET    = 64'd338803074408735;
   localparam logic [15:0] GAIN_P_RESET = 16'd51200;
   localparam logic [7:0]  BASE_RESET   = 8'd75;

   localparam int LOST_MS      = 1000;
   localparam int DT_MAX       = 1000;
   localparam int DT_DEFAULT   = 20;
   localparam int DEADBAND     = 40;
   localparam int IACC_MAX     = 204800000;
   localparam int SPIN_A_MS    = 200;
   localparam int SPIN_B_MS    = 1600;
   localparam int SPIN_A_BOOST = 30;
   localparam int SPIN_B_BOOST = 20;
   localparam int MS_PER_S     = 1000;
   localparam int D_SCALE      = 1000000;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_THRESHOLDS    = 3'd0,
      REG_LINE_IS_LIGHT = 3'd1,
      REG_GAIN_P        = 3'd2,
      REG_GAIN_I        = 3'd3,
      REG_GAIN_D        = 3'd4,
      REG_BASE_SPEED    = 3'd5,
      REG_SEARCH_ENABLE = 3'd6
   } lfpid_reg_type;

   typedef struct packed {
      logic                    halt;
      logic [NUM_SENSORS-1:0]  mask;
      logic signed [ERR_W-1:0] err;
      logic [31:0]             now;
   } lfpid_item_type;

   typedef struct packed {
      logic [GAIN_W-1:0] gain_p;
      logic [GAIN_W-1:0] gain_i;
      logic [GAIN_W-1:0] gain_d;
      logic [7:0]        base_speed;
      logic              search_enable;
   } lfpid_cfg_type;

   // Weighted mean of the on-line sensor weights in Q10, rounded.
   function automatic logic signed [ERR_W-1:0] err_of_mask(input logic [NUM_SENSORS-1:0] m);
      logic signed [ERR_W-1:0] e;
      case (m)
         5'd1:    e = -14'sd4096;
         5'd2:    e = -14'sd2048;
         5'd3:    e = -14'sd3072;
         5'd5:    e = -14'sd2048;
         5'd6:    e = -14'sd1024;
         5'd7:    e = -14'sd2048;
         5'd8:    e = 14'sd2048;
         5'd9:    e = -14'sd1024;
         5'd11:   e = -14'sd1365;
         5'd12:   e = 14'sd1024;
         5'd13:   e = -14'sd683;
         5'd15:   e = -14'sd1024;
         5'd16:   e = 14'sd4096;
         5'd18:   e = 14'sd1024;
         5'd19:   e = -14'sd683;
         5'd20:   e = 14'sd2048;
         5'd22:   e = 14'sd683;
         5'd23:   e = -14'sd512;
         5'd24:   e = 14'sd3072;
         5'd25:   e = 14'sd683;
         5'd26:   e = 14'sd1365;
         5'd28:   e = 14'sd2048;
         5'd29:   e = 14'sd512;
         5'd30:   e = 14'sd1024;
         default: e = 14'sd0;
      endcase
      return e;
   endfunction

endpackage

// ===== hdl/lfpid_if.sv =====
// Interfaces: sensor frame, drive command and register write channels.
`timescale 1ns / 1ps
interface lfpid_req_if #(parameter int SAMPLE_BITS = lfpid_pkg::SAMPLE_BITS_DEF);
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] sample_left;
   logic [SAMPLE_BITS-1:0] sample_mid_left;
   logic [SAMPLE_BITS-1:0] sample_middle;
   logic [SAMPLE_BITS-1:0] sample_mid_right;
   logic [SAMPLE_BITS-1:0] sample_right;
   logic [31:0]            now_ms;
   logic                   halt;
   modport source (output valid, sample_left, sample_mid_left, sample_middle,
                   sample_mid_right, sample_right, now_ms, halt, input ready);
   modport sink (input valid, sample_left, sample_mid_left, sample_middle,
                 sample_mid_right, sample_right, now_ms, halt, output ready);
endinterface

interface lfpid_rsp_if;
   logic       valid;
   logic       ready;
   logic       left_reverse;
   logic [7:0] left_speed;
   logic       right_reverse;
   logic [7:0] right_speed;
   logic       drive_valid;
   logic [4:0] on_line_mask;
   logic       searching;
   modport source (output valid, left_reverse, left_speed, right_reverse, right_speed,
                   drive_valid, on_line_mask, searching, input ready);
   modport sink (input valid, left_reverse, left_speed, right_reverse, right_speed,
                 drive_valid, on_line_mask, searching, output ready);
endinterface

interface lfpid_csr_if #(parameter int DATA_W = 5 * lfpid_pkg::SAMPLE_BITS_DEF);
   logic                             valid;
   logic                             ready;
   logic [lfpid_pkg::CSR_IDX_W-1:0] index;
   logic [DATA_W-1:0]                data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/lfpid_front.sv =====
// Front end: thresholds the samples, forms mask and error, one beat stage.
`timescale 1ns / 1ps
module lfpid_front #(
   parameter int SAMPLE_BITS = lfpid_pkg::SAMPLE_BITS_DEF,
   parameter int THR_W       = 5 * lfpid_pkg::SAMPLE_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   lfpid_req_if.sink                 req,
   input  logic [THR_W-1:0]          thresholds,
   input  logic                      line_is_light,
   output lfpid_pkg::lfpid_item_type item,
   output logic                      item_valid,
   input  logic                      item_ready
);
   localparam int NS = lfpid_pkg::NUM_SENSORS;

   logic [SAMPLE_BITS-1:0] smp [NS];
   logic [SAMPLE_BITS-1:0] thr [NS];
   logic [NS-1:0]          mask;
   logic                   stage_valid_ff, stage_valid_in;
   lfpid_pkg::lfpid_item_type stage_ff, stage_in;

   assign smp[0] = req.sample_left;
   assign smp[1] = req.sample_mid_left;
   assign smp[2] = req.sample_middle;
   assign smp[3] = req.sample_mid_right;
   assign smp[4] = req.sample_right;

   for (genvar i = 0; i < NS; i++) begin : g_sens
      for (genvar j = 0; j < SAMPLE_BITS; j++) begin : g_bit
         if (i * SAMPLE_BITS + j < THR_W) begin : g_in
            assign thr[i][j] = thresholds[i * SAMPLE_BITS + j];
         end else begin : g_out
            assign thr[i][j] = 1'b0;
         end
      end
      assign mask[i] = line_is_light ? (smp[i] >= thr[i]) : (smp[i] < thr[i]);
   end

   assign req.ready  = !stage_valid_ff || item_ready;
   assign item       = stage_ff;
   assign item_valid = stage_valid_ff;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      stage_in       = stage_ff;
      if (stage_valid_ff && item_ready) begin
         stage_valid_in = 1'b0;
      end
      if (req.valid && req.ready) begin
         stage_valid_in = 1'b1;
         stage_in.halt  = req.halt;
         stage_in.mask  = mask;
         stage_in.err   = lfpid_pkg::err_of_mask(mask);
         stage_in.now   = req.now_ms;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
      stage_ff <= stage_in;
   end
endmodule

// ===== hdl/lfpid_fifo.sv =====
// Short queue between front and back ends.
`timescale 1ns / 1ps
module lfpid_fifo (
   input  logic                      clock,
   input  logic                      reset,
   input  lfpid_pkg::lfpid_item_type push_item,
   input  logic                      push_valid,
   output logic                      push_ready,
   output lfpid_pkg::lfpid_item_type pop_item,
   output logic                      pop_valid,
   input  logic                      pop
);
   localparam int DEPTH = lfpid_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   lfpid_pkg::lfpid_item_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end
endmodule

// ===== hdl/lfpid_back.sv =====
// Back end: search and PID state, sequenced PID math, output register.
`timescale 1ns / 1ps
module lfpid_back #(
   parameter int SPEED_LIMIT = lfpid_pkg::SPEED_LIMIT_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  lfpid_pkg::lfpid_cfg_type  cfg,
   input  lfpid_pkg::lfpid_item_type item,
   input  logic                      item_valid,
   output logic                      item_pop,
   lfpid_rsp_if.source               rsp
);
   localparam int ERR_W = lfpid_pkg::ERR_W;
   localparam int DT_W  = lfpid_pkg::DT_W;
   localparam int ACC_W = lfpid_pkg::ACC_W;
   localparam int K_W   = 20;
   localparam int NUM_W = 56;
   localparam int DEN_W = K_W + 20;
   localparam int CNT_W = $clog2(NUM_W);
   localparam int Q_W   = 12;
   localparam logic [15:0] LIM16 = 16'(SPEED_LIMIT);

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_PREP = 7'b0000010,
      S_MUL1 = 7'b0000100,
      S_MUL2 = 7'b0001000,
      S_SUM  = 7'b0010000,
      S_DIV  = 7'b0100000,
      S_FIN  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   logic signed [ACC_W-1:0] integral_ff, integral_in;
   logic signed [ERR_W-1:0] prev_ff, prev_in;
   logic [31:0]             last_ff, last_in;
   logic                    started_ff, started_in;
   logic                    lost_timing_ff, lost_timing_in;
   logic [31:0]             lost_start_ff, lost_start_in;
   logic                    search_ff, search_in;
   logic [31:0]             search_start_ff, search_start_in;

   logic signed [ERR_W-1:0] e_ff, e_in;
   logic [DT_W-1:0]         dt_ff, dt_in;
   logic signed [ERR_W:0]   de_ff, de_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic [K_W-1:0]          k_ff, k_in;
   logic signed [29:0]      p1_ff, p1_in;
   logic signed [44:0]      p2_ff, p2_in;
   logic signed [30:0]      p3_ff, p3_in;
   logic signed [49:0]      t1_ff, t1_in;
   logic signed [54:0]      t2_ff, t2_in;
   logic signed [50:0]      t3_ff, t3_in;
   logic [NUM_W-1:0]        num_ff, num_in;
   logic [DEN_W-1:0]        rem_ff, rem_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic                    neg_ff, neg_in;
   logic [4:0]              mask_ff, mask_in;

   logic       out_valid_ff, out_valid_in;
   logic       lrev_ff, lrev_in, rrev_ff, rrev_in, dv_ff, dv_in, srch_ff, srch_in;
   logic [7:0] lspd_ff, lspd_in, rspd_ff, rspd_in;
   logic [4:0] omask_ff, omask_in;

   logic                    out_free;
   logic [31:0]             ls, ss, tdiff, dtdiff;
   logic                    sa, quick;
   logic signed [ERR_W-1:0] e_sel;
   logic signed [24:0]      ed;
   logic signed [ACC_W:0]   asum;
   logic signed [56:0]      nsum;
   logic [DEN_W:0]          shv, den;
   logic [Q_W-1:0]          qs;
   logic signed [15:0]      corr, lv, rv, bv;
   logic [15:0]             b30, b20;

   function automatic logic [7:0] spin_mag(input logic [15:0] m);
      return (m > LIM16) ? LIM16[7:0] : m[7:0];
   endfunction

   function automatic logic [7:0] wheel_mag(input logic signed [15:0] v);
      logic [7:0] r;
      if (v < 0) begin
         r = 8'd0;
      end else if (v > $signed(LIM16)) begin
         r = LIM16[7:0];
      end else begin
         r = v[7:0];
      end
      return r;
   endfunction

   assign out_free          = !out_valid_ff || rsp.ready;
   assign rsp.valid         = out_valid_ff;
   assign rsp.left_reverse  = lrev_ff;
   assign rsp.left_speed    = lspd_ff;
   assign rsp.right_reverse = rrev_ff;
   assign rsp.right_speed   = rspd_ff;
   assign rsp.drive_valid   = dv_ff;
   assign rsp.on_line_mask  = omask_ff;
   assign rsp.searching     = srch_ff;
   assign item_pop          = (state_ff == S_IDLE) && item_valid && out_free;

   always_comb begin
      state_in        = state_ff;
      integral_in     = integral_ff;
      prev_in         = prev_ff;
      last_in         = last_ff;
      started_in      = started_ff;
      lost_timing_in  = lost_timing_ff;
      lost_start_in   = lost_start_ff;
      search_in       = search_ff;
      search_start_in = search_start_ff;
      e_in   = e_ff;   dt_in  = dt_ff;  de_in  = de_ff;  acc_in = acc_ff;
      k_in   = k_ff;   p1_in  = p1_ff;  p2_in  = p2_ff;  p3_in  = p3_ff;
      t1_in  = t1_ff;  t2_in  = t2_ff;  t3_in  = t3_ff;
      num_in = num_ff; rem_in = rem_ff; cnt_in = cnt_ff; neg_in = neg_ff;
      mask_in = mask_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      lrev_in = lrev_ff; lspd_in = lspd_ff; rrev_in = rrev_ff; rspd_in = rspd_ff;
      dv_in = dv_ff; omask_in = omask_ff; srch_in = srch_ff;
      ls = lost_start_ff; ss = search_start_ff; tdiff = '0; dtdiff = '0;
      sa = search_ff; quick = 1'b0; e_sel = prev_ff;
      ed = '0; asum = '0; nsum = '0; shv = '0; den = '0; qs = '0;
      corr = '0; lv = '0; rv = '0;
      bv  = $signed({8'd0, cfg.base_speed});
      b30 = {8'd0, cfg.base_speed} + 16'(lfpid_pkg::SPIN_A_BOOST);
      b20 = {8'd0, cfg.base_speed} + 16'(lfpid_pkg::SPIN_B_BOOST);

      case (state_ff)
         S_IDLE: begin
            if (item_pop) begin
               mask_in  = item.mask;
               omask_in = item.mask;
               lrev_in  = 1'b0; rrev_in = 1'b0;
               lspd_in  = 8'd0; rspd_in = 8'd0;
               dv_in    = 1'b1; srch_in = 1'b0;
               if (item.halt) begin
                  integral_in  = '0;
                  prev_in      = '0;
                  started_in   = 1'b0;
                  search_in    = 1'b0;
                  out_valid_in = 1'b1;
               end else begin
                  if (cfg.search_enable && item.mask == '0) begin
                     if (!search_ff) begin
                        ls             = lost_timing_ff ? lost_start_ff : item.now;
                        lost_timing_in = 1'b1;
                        lost_start_in  = ls;
                        if (item.now - ls > 32'(lfpid_pkg::LOST_MS)) begin
                           integral_in     = '0;
                           prev_in         = '0;
                           started_in      = 1'b0;
                           search_in       = 1'b1;
                           search_start_in = item.now;
                           sa              = 1'b1;
                           ss              = item.now;
                        end
                     end
                     if (sa) begin
                        quick   = 1'b1;
                        tdiff   = item.now - ss;
                        srch_in = 1'b1;
                        if (tdiff < 32'(lfpid_pkg::SPIN_A_MS)) begin
                           lspd_in = spin_mag(b30);
                           rrev_in = 1'b1;
                           rspd_in = spin_mag(b30);
                        end else if (tdiff < 32'(lfpid_pkg::SPIN_B_MS)) begin
                           lrev_in = 1'b1;
                           lspd_in = spin_mag(b20);
                           rspd_in = spin_mag(b20);
                        end else begin
                           dv_in = 1'b0;
                        end
                        out_valid_in = 1'b1;
                     end
                  end else if (cfg.search_enable) begin
                     lost_timing_in = 1'b0;
                     search_in      = 1'b0;
                  end
                  if (!quick) begin
                     e_sel = (item.mask == '0) ? prev_ff : item.err;
                     last_in = item.now;
                     prev_in = e_sel;
                     if (!started_ff) begin
                        started_in   = 1'b1;
                        lspd_in      = wheel_mag(bv);
                        rspd_in      = wheel_mag(bv);
                        out_valid_in = 1'b1;
                     end else begin
                        dtdiff = item.now - last_ff;
                        dt_in  = (dtdiff == '0 || dtdiff > 32'(lfpid_pkg::DT_MAX)) ?
                                 DT_W'(lfpid_pkg::DT_DEFAULT) : dtdiff[DT_W-1:0];
                        e_in     = e_sel;
                        de_in    = (ERR_W+1)'(e_sel) - (ERR_W+1)'(prev_ff);
                        state_in = S_PREP;
                     end
                  end
               end
            end
         end
         S_PREP: begin
            ed   = e_ff * $signed({1'b0, dt_ff});
            asum = (ACC_W+1)'(integral_ff) + (ACC_W+1)'(ed);
            if (e_ff >= -lfpid_pkg::DEADBAND && e_ff <= lfpid_pkg::DEADBAND) begin
               acc_in = '0;
            end else if (asum > lfpid_pkg::IACC_MAX) begin
               acc_in = ACC_W'(lfpid_pkg::IACC_MAX);
            end else if (asum < -lfpid_pkg::IACC_MAX) begin
               acc_in = ACC_W'(-lfpid_pkg::IACC_MAX);
            end else begin
               acc_in = asum[ACC_W-1:0];
            end
            integral_in = acc_in;
            k_in        = K_W'(dt_ff) * K_W'(lfpid_pkg::MS_PER_S);
            state_in    = S_MUL1;
         end
         S_MUL1: begin
            p1_in    = $signed({1'b0, cfg.gain_p}) * e_ff;
            p2_in    = $signed({1'b0, cfg.gain_i}) * acc_ff;
            p3_in    = $signed({1'b0, cfg.gain_d}) * de_ff;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            t1_in    = p1_ff * $signed({1'b0, k_ff});
            t2_in    = p2_ff * $signed({1'b0, dt_ff});
            t3_in    = p3_ff * $signed(21'(lfpid_pkg::D_SCALE));
            state_in = S_SUM;
         end
         S_SUM: begin
            nsum     = 57'(t1_ff) + 57'(t2_ff) + 57'(t3_ff);
            neg_in   = nsum[56];
            num_in   = nsum[56] ? NUM_W'(-nsum) : nsum[NUM_W-1:0];
            rem_in   = '0;
            cnt_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            shv = {rem_ff, num_ff[NUM_W-1]};
            den = {1'b0, k_ff, 20'd0};
            if (shv >= den) begin
               rem_in = DEN_W'(shv - den);
               num_in = {num_ff[NUM_W-2:0], 1'b1};
            end else begin
               rem_in = shv[DEN_W-1:0];
               num_in = {num_ff[NUM_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(NUM_W - 1)) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (out_free) begin
               qs   = (|num_ff[NUM_W-1:Q_W]) ? '1 : num_ff[Q_W-1:0];
               corr = neg_ff ? -$signed({4'd0, qs}) : $signed({4'd0, qs});
               lv   = bv - corr;
               rv   = bv + corr;
               lrev_in = 1'b0; rrev_in = 1'b0;
               lspd_in = wheel_mag(lv);
               rspd_in = wheel_mag(rv);
               dv_in   = 1'b1; srch_in = 1'b0;
               omask_in = mask_ff;
               out_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         integral_ff     <= '0;
         prev_ff         <= '0;
         last_ff         <= '0;
         started_ff      <= 1'b0;
         lost_timing_ff  <= 1'b0;
         lost_start_ff   <= '0;
         search_ff       <= 1'b0;
         search_start_ff <= '0;
         out_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         integral_ff     <= integral_in;
         prev_ff         <= prev_in;
         last_ff         <= last_in;
         started_ff      <= started_in;
         lost_timing_ff  <= lost_timing_in;
         lost_start_ff   <= lost_start_in;
         search_ff       <= search_in;
         search_start_ff <= search_start_in;
         out_valid_ff    <= out_valid_in;
      end
      e_ff <= e_in;   dt_ff <= dt_in;   de_ff <= de_in;   acc_ff <= acc_in;
      k_ff <= k_in;   p1_ff <= p1_in;   p2_ff <= p2_in;   p3_ff <= p3_in;
      t1_ff <= t1_in; t2_ff <= t2_in;   t3_ff <= t3_in;
      num_ff <= num_in; rem_ff <= rem_in; cnt_ff <= cnt_in; neg_ff <= neg_in;
      mask_ff <= mask_in;
      lrev_ff <= lrev_in; lspd_ff <= lspd_in; rrev_ff <= rrev_in; rspd_ff <= rspd_in;
      dv_ff <= dv_in; omask_ff <= omask_in; srch_ff <= srch_in;
   end
endmodule

// ===== hdl/line_follow_pid_controller_unit.sv =====
// Top level: register file, front end, queue and back end of the line-follower PID.
//
//   channel  | dir | beat
//   req_bus  | in  | five IR samples, now_ms, halt
//   rsp_bus  | out | wheel directions and speeds, drive_valid, mask, searching
//   csr_bus  | in  | register index and write data, always ready
//
// Halt, search and first-frame beats finish in the cycle after they leave the queue.
// A PID beat steps through S_PREP, S_MUL1, S_MUL2, S_SUM, the 56-step restoring
// divider for the correction and S_FIN; front end and queue take beats until full.
// A stalled rsp_bus holds its beat; reset clears the PID, search and handshake state.
`timescale 1ns / 1ps
module line_follow_pid_controller_unit #(
   parameter int SPEED_LIMIT = lfpid_pkg::SPEED_LIMIT_DEF,
   parameter int SAMPLE_BITS = lfpid_pkg::SAMPLE_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   lfpid_req_if.sink   req_bus,
   lfpid_rsp_if.source rsp_bus,
   lfpid_csr_if.sink   csr_bus
);
   localparam int CSR_W = lfpid_pkg::NUM_SENSORS * SAMPLE_BITS;
   localparam int THR_W = (CSR_W > 64) ? 64 : CSR_W;

   logic [THR_W-1:0]  thr_ff, thr_in;
   logic              light_ff, light_in;
   lfpid_pkg::lfpid_cfg_type cfg_ff, cfg_in;

   lfpid_pkg::lfpid_item_type fr_item, q_item;
   logic fr_valid, fr_ready, q_valid, q_pop;

   assign csr_bus.ready = 1'b1;

   always_comb begin
      thr_in   = thr_ff;
      light_in = light_ff;
      cfg_in   = cfg_ff;
      if (csr_bus.valid) begin
         case (csr_bus.index)
            lfpid_pkg::REG_THRESHOLDS:    thr_in = csr_bus.data[THR_W-1:0];
            lfpid_pkg::REG_LINE_IS_LIGHT: light_in = csr_bus.data[0];
            lfpid_pkg::REG_GAIN_P:        cfg_in.gain_p = csr_bus.data[15:0];
            lfpid_pkg::REG_GAIN_I:        cfg_in.gain_i = csr_bus.data[15:0];
            lfpid_pkg::REG_GAIN_D:        cfg_in.gain_d = csr_bus.data[15:0];
            lfpid_pkg::REG_BASE_SPEED:    cfg_in.base_speed = csr_bus.data[7:0];
            lfpid_pkg::REG_SEARCH_ENABLE: cfg_in.search_enable = csr_bus.data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff               <= lfpid_pkg::THR_RESET[THR_W-1:0];
         light_ff             <= 1'b1;
         cfg_ff.gain_p        <= lfpid_pkg::GAIN_P_RESET;
         cfg_ff.gain_i        <= '0;
         cfg_ff.gain_d        <= '0;
         cfg_ff.base_speed    <= lfpid_pkg::BASE_RESET;
         cfg_ff.search_enable <= 1'b1;
      end else begin
         thr_ff   <= thr_in;
         light_ff <= light_in;
         cfg_ff   <= cfg_in;
      end
   end

   lfpid_front #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .THR_W       (THR_W)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req           (req_bus),
      .thresholds    (thr_ff),
      .line_is_light (light_ff),
      .item          (fr_item),
      .item_valid    (fr_valid),
      .item_ready    (fr_ready)
   );

   lfpid_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_item  (fr_item),
      .push_valid (fr_valid),
      .push_ready (fr_ready),
      .pop_item   (q_item),
      .pop_valid  (q_valid),
      .pop        (q_pop)
   );

   lfpid_back #(
      .SPEED_LIMIT (SPEED_LIMIT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item       (q_item),
      .item_valid (q_valid),
      .item_pop   (q_pop),
      .rsp        (rsp_bus)
   );
endmodule

// ===== hdl/lfpid_checker.sv =====
// Checker on the drive command port, bound to the top level.
`timescale 1ns / 1ps
module lfpid_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       left_reverse,
   input logic [7:0] left_speed,
   input logic       right_reverse,
   input logic [7:0] right_speed,
   input logic       drive_valid,
   input logic [4:0] on_line_mask,
   input logic       searching
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(left_speed) &&
      $stable(right_speed) && $stable(drive_valid) && $stable(on_line_mask))
      else $error("drive beat changed while stalled");

   a_search_mask: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && searching |-> on_line_mask == 5'd0)
      else $error("search beat with line seen");

   a_no_drive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !drive_valid |-> searching && left_speed == 8'd0 &&
      right_speed == 8'd0 && !left_reverse && !right_reverse)
      else $error("idle drive outside search or with nonzero command");

   a_direction: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && drive_valid |-> (searching ? (left_reverse != right_reverse)
                                              : (!left_reverse && !right_reverse)))
      else $error("wheel direction inconsistent with mode");
endmodule

bind line_follow_pid_controller_unit lfpid_checker u_lfpid_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .left_reverse  (rsp_bus.left_reverse),
   .left_speed    (rsp_bus.left_speed),
   .right_reverse (rsp_bus.right_reverse),
   .right_speed   (rsp_bus.right_speed),
   .drive_valid   (rsp_bus.drive_valid),
   .on_line_mask  (rsp_bus.on_line_mask),
   .searching     (rsp_bus.searching)
);

// ===== dv/line_follow_pid_controller_unit_tb.sv =====
// Testbench: directed and random sensor frames, checked against a built-in PID drive predictor.
`timescale 1ns / 1ps
module line_follow_pid_controller_unit_tb;

   localparam int          SPD_MAX   = 250;
   localparam int          CYCLE_CAP = 1500000;
   localparam logic [49:0] ALL_ON    = {50{1'b1}};
   localparam int          PHASES    = 7;
   localparam int          PHASE_LEN = 150;

   typedef struct packed {
      bit       lrev;
      bit [7:0] lspd;
      bit       rrev;
      bit [7:0] rspd;
      bit       dv;
      bit [4:0] mask;
      bit       srch;
   } drive_type;

   typedef struct packed {
      bit [49:0] smp;
      bit [31:0] now;
      bit        halt;
      bit        typed;
      drive_type exp;
   } frame_row_type;

   localparam drive_type FWD75 = '{0, 8'd75, 0, 8'd75, 1, 5'd31, 0};
   localparam drive_type STOP  = '{0, 8'd0, 0, 8'd0, 1, 5'd31, 0};

   localparam frame_row_type DIR_ROWS[23] = '{
      '{ALL_ON, 32'd100, 1'b0, 1'b1, FWD75},
      '{ALL_ON, 32'd110, 1'b1, 1'b1, STOP},
      '{ALL_ON, 32'd120, 1'b0, 1'b1, FWD75},
      '{ALL_ON, 32'd120, 1'b0, 1'b0, '0},
      '{50'h3FF, 32'd130, 1'b0, 1'b0, '0},
      '{50'h3FF << 10, 32'd140, 1'b0, 1'b0, '0},
      '{50'h3FF << 20, 32'd150, 1'b0, 1'b0, '0},
      '{50'h3FF << 30, 32'd160, 1'b0, 1'b0, '0},
      '{50'h3FF << 40, 32'd170, 1'b0, 1'b0, '0},
      '{50'hFFFFF, 32'd180, 1'b0, 1'b0, '0},
      '{50'h0, 32'd200, 1'b0, 1'b0, '0},
      '{50'h0, 32'd1300, 1'b0, 1'b0, '0},
      '{50'h0, 32'd1400, 1'b0, 1'b0, '0},
      '{50'h0, 32'd1500, 1'b0, 1'b0, '0},
      '{50'h0, 32'd2900, 1'b0, 1'b0, '0},
      '{50'h0, 32'd3000, 1'b0, 1'b0, '0},
      '{ALL_ON, 32'd3010, 1'b0, 1'b0, '0},
      '{ALL_ON, 32'd5000, 1'b0, 1'b0, '0},
      '{50'h3FF, 32'hFFFF_FFF0, 1'b0, 1'b0, '0},
      '{50'h3FF << 40, 32'd5, 1'b0, 1'b0, '0},
      '{50'h1555555555555, 32'd6000, 1'b0, 1'b0, '0},
      '{50'h2AAAAAAAAAAAA, 32'd6010, 1'b0, 1'b0, '0},
      '{50'h0, 32'hFFFF_FFFF, 1'b1, 1'b0, '0}
   };

   logic clock;
   logic reset;
   lfpid_req_if req_bus();
   lfpid_rsp_if rsp_bus();
   lfpid_csr_if csr_bus();

   line_follow_pid_controller_unit uut (
      .clock(clock), .reset(reset), .req_bus(req_bus), .rsp_bus(rsp_bus), .csr_bus(csr_bus)
   );

   // predictor configuration and state
   bit [49:0] thr_cfg;
   bit        light_cfg, srch_en_cfg;
   bit [15:0] gp_cfg, gi_cfg, gd_cfg;
   bit [7:0]  base_cfg;
   int        iacc;
   shortint   prev_err;
   bit [31:0] last_t, lost_t0, srch_t0;
   bit        started, lost_on, srch_on;

   drive_type drive_q[$];
   int        errs;
   int        cycles;
   bit [31:0] clk_ms;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic bit [9:0] thr_of(int i);
      return thr_cfg[i*10 +: 10];
   endfunction

   function automatic void put_wheel(longint v, output bit rev, output bit [7:0] spd);
      longint mag;
      mag = v < 0 ? -v : v;
      if (mag > SPD_MAX) mag = SPD_MAX;
      rev = v < 0;
      spd = mag[7:0];
   endfunction

   function automatic drive_type predict_drive(bit [49:0] smp, bit [31:0] now, bit halt);
      drive_type d;
      int     num, cnt, e, n, a, q;
      bit     on;
      bit [31:0] t, dt;
      longint base, acc, de, pnum, den, corr, l, r, dtl;
      d = '0;
      num = 0;
      cnt = 0;
      base = base_cfg;
      for (int i = 0; i < 5; i++) begin
         on = light_cfg ? (smp[i*10 +: 10] >= thr_of(i)) : (smp[i*10 +: 10] < thr_of(i));
         if (on) begin
            d.mask[i] = 1;
            num += 2 * i - 4;
            cnt++;
         end
      end
      if (halt) begin
         iacc = 0;
         prev_err = 0;
         started = 0;
         srch_on = 0;
         d.dv = 1;
         return d;
      end
      if (srch_en_cfg) begin
         if (d.mask == 0) begin
            if (!srch_on) begin
               if (!lost_on) begin
                  lost_on = 1;
                  lost_t0 = now;
               end
               if (now - lost_t0 > 32'd1000) begin
                  iacc = 0;
                  prev_err = 0;
                  started = 0;
                  srch_on = 1;
                  srch_t0 = now;
               end
            end
            if (srch_on) begin
               t = now - srch_t0;
               d.srch = 1;
               if (t < 200) begin
                  put_wheel(base + 30, d.lrev, d.lspd);
                  put_wheel(-(base + 30), d.rrev, d.rspd);
                  d.dv = 1;
               end else if (t < 1600) begin
                  put_wheel(-(base + 20), d.lrev, d.lspd);
                  put_wheel(base + 20, d.rrev, d.rspd);
                  d.dv = 1;
               end
               return d;
            end
         end else begin
            lost_on = 0;
            srch_on = 0;
         end
      end
      if (cnt == 0) begin
         e = prev_err;
      end else begin
         n = num * 1024;
         a = n < 0 ? -n : n;
         q = (a + cnt / 2) / cnt;
         e = n < 0 ? -q : q;
      end
      d.dv = 1;
      if (!started) begin
         started = 1;
         last_t = now;
         prev_err = shortint'(e);
         put_wheel(base, d.lrev, d.lspd);
         put_wheel(base, d.rrev, d.rspd);
         return d;
      end
      dt = now - last_t;
      if (dt == 0 || dt > 1000) dt = 20;
      dtl = dt;
      last_t = now;
      if (e >= -40 && e <= 40) begin
         acc = 0;
      end else begin
         acc = longint'(iacc) + longint'(e) * dtl;
         if (acc > 204800000) acc = 204800000;
         if (acc < -204800000) acc = -204800000;
      end
      iacc = int'(acc);
      de = longint'(e) - longint'(prev_err);
      prev_err = shortint'(e);
      pnum = longint'(gp_cfg) * e * 1000 * dtl + longint'(gi_cfg) * acc * dtl
           + longint'(gd_cfg) * de * 1000000;
      den = longint'(1048576) * 1000 * dtl;
      corr = pnum / den;
      l = base - corr;
      r = base + corr;
      if (l < 0) l = 0;
      if (l > SPD_MAX) l = SPD_MAX;
      if (r < 0) r = 0;
      if (r > SPD_MAX) r = SPD_MAX;
      put_wheel(l, d.lrev, d.lspd);
      put_wheel(r, d.rrev, d.rspd);
      return d;
   endfunction

   function automatic void check_field(string name, int exp, int act);
      if (exp != act) begin
         $error("%s: expected %0d, got %0d", name, exp, act);
         errs++;
      end
   endfunction

   always @(posedge clock) begin
      drive_type x;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (drive_q.size() == 0) begin
            $error("drive beat with nothing expected");
            errs++;
         end else begin
            x = drive_q.pop_front();
            check_field("left_reverse", x.lrev, rsp_bus.left_reverse);
            check_field("left_speed", x.lspd, rsp_bus.left_speed);
            check_field("right_reverse", x.rrev, rsp_bus.right_reverse);
            check_field("right_speed", x.rspd, rsp_bus.right_speed);
            check_field("drive_valid", x.dv, rsp_bus.drive_valid);
            check_field("on_line_mask", x.mask, rsp_bus.on_line_mask);
            check_field("searching", x.srch, rsp_bus.searching);
         end
      end
   end

   // sink stalls: stall-free stretches, short stalls, occasional long ones
   int stall_left, free_left;
   always @(posedge clock) begin
      int r;
      if (reset) begin
         rsp_bus.ready <= 0;
      end else if (free_left > 0) begin
         free_left <= free_left - 1;
         rsp_bus.ready <= 1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_bus.ready <= 0;
      end else begin
         r = $urandom_range(0, 99);
         rsp_bus.ready <= 1;
         if (r < 10) free_left <= $urandom_range(50, 300);
         else if (r < 40) stall_left <= $urandom_range(1, 3);
         else if (r < 45) stall_left <= $urandom_range(10, 60);
      end
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 50);
   endfunction

   task automatic send_frame(bit [49:0] smp, bit [31:0] now, bit halt, bit typed,
                             drive_type exp, bit no_gap);
      drive_type p;
      int        g;
      req_bus.valid            <= 1;
      req_bus.sample_left      <= smp[9:0];
      req_bus.sample_mid_left  <= smp[19:10];
      req_bus.sample_middle    <= smp[29:20];
      req_bus.sample_mid_right <= smp[39:30];
      req_bus.sample_right     <= smp[49:40];
      req_bus.now_ms           <= now;
      req_bus.halt             <= halt;
      do @(posedge clock); while (!req_bus.ready);
      p = predict_drive(smp, now, halt);
      drive_q.push_back(typed ? exp : p);
      g = no_gap ? 0 : gap_len();
      if (g > 0) begin
         req_bus.valid <= 0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_bus.valid <= 0;
      @(posedge clock);
      while (drive_q.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // leaves valid high so back-to-back writes need no second assignment
   task automatic csr_write(lfpid_pkg::lfpid_reg_type idx, bit [49:0] val);
      csr_bus.valid <= 1;
      csr_bus.index <= idx;
      csr_bus.data  <= val;
      do @(posedge clock); while (!csr_bus.ready);
      case (idx)
         lfpid_pkg::REG_THRESHOLDS:    thr_cfg = val;
         lfpid_pkg::REG_LINE_IS_LIGHT: light_cfg = val[0];
         lfpid_pkg::REG_GAIN_P:        gp_cfg = val[15:0];
         lfpid_pkg::REG_GAIN_I:        gi_cfg = val[15:0];
         lfpid_pkg::REG_GAIN_D:        gd_cfg = val[15:0];
         lfpid_pkg::REG_BASE_SPEED:    base_cfg = val[7:0];
         lfpid_pkg::REG_SEARCH_ENABLE: srch_en_cfg = val[0];
         default: ;
      endcase
   endtask

   function automatic bit [49:0] rand50();
      return {18'($urandom()), $urandom()};
   endfunction

   task automatic set_phase(int ph);
      bit [49:0] thr;
      case (ph)
         1: begin
            csr_write(lfpid_pkg::REG_THRESHOLDS, rand50());
            csr_write(lfpid_pkg::REG_LINE_IS_LIGHT, 0);
            csr_write(lfpid_pkg::REG_GAIN_P, 16'hFFFF);
            csr_write(lfpid_pkg::REG_GAIN_I, 16'hFFFF);
            csr_write(lfpid_pkg::REG_GAIN_D, 16'hFFFF);
            csr_write(lfpid_pkg::REG_BASE_SPEED, 250);
            csr_write(lfpid_pkg::REG_SEARCH_ENABLE, 1);
         end
         2: begin
            csr_write(lfpid_pkg::REG_THRESHOLDS, 0);
            csr_write(lfpid_pkg::REG_LINE_IS_LIGHT, 1);
            csr_write(lfpid_pkg::REG_GAIN_P, 0);
            csr_write(lfpid_pkg::REG_GAIN_I, 0);
            csr_write(lfpid_pkg::REG_GAIN_D, 0);
            csr_write(lfpid_pkg::REG_BASE_SPEED, 0);
            csr_write(lfpid_pkg::REG_SEARCH_ENABLE, 0);
         end
         3: begin
            csr_write(lfpid_pkg::REG_THRESHOLDS, ALL_ON);
            csr_write(lfpid_pkg::REG_LINE_IS_LIGHT, 0);
            csr_write(lfpid_pkg::REG_GAIN_P, $urandom_range(0, 65535));
            csr_write(lfpid_pkg::REG_GAIN_I, $urandom_range(0, 65535));
            csr_write(lfpid_pkg::REG_GAIN_D, $urandom_range(0, 65535));
            csr_write(lfpid_pkg::REG_BASE_SPEED, $urandom_range(0, 250));
            csr_write(lfpid_pkg::REG_SEARCH_ENABLE, 1);
         end
         default: begin
            for (int i = 0; i < 5; i++) thr[i*10 +: 10] = $urandom_range(100, 900);
            csr_write(lfpid_pkg::REG_THRESHOLDS, thr);
            csr_write(lfpid_pkg::REG_LINE_IS_LIGHT, $urandom_range(0, 1));
            csr_write(lfpid_pkg::REG_GAIN_P, $urandom_range(0, 65535));
            csr_write(lfpid_pkg::REG_GAIN_I, ph == 6 ? 16'hFFFF : $urandom_range(0, 65535));
            csr_write(lfpid_pkg::REG_GAIN_D, $urandom_range(0, 65535));
            csr_write(lfpid_pkg::REG_BASE_SPEED, $urandom_range(0, 250));
            csr_write(lfpid_pkg::REG_SEARCH_ENABLE, ph != 4);
         end
      endcase
      csr_bus.valid <= 0;
   endtask

   function automatic bit [9:0] pick_sample(int i, bit on);
      bit [9:0] t;
      t = thr_of(i);
      if (light_cfg == on) return t == 0 && !on ? 10'($urandom()) : 10'($urandom_range(1023, t));
      return t == 0 ? 10'($urandom()) : 10'($urandom_range(t - 1, 0));
   endfunction

   function automatic bit [31:0] ms_step();
      int r;
      r = $urandom_range(0, 99);
      if (r < 85) return $urandom_range(1, 30);
      if (r < 90) return 0;
      if (r < 95) return $urandom_range(1001, 5000);
      return $urandom_range(31, 1000);
   endfunction

   initial begin
      int        done, seg, len;
      bit [4:0]  want;
      bit [49:0] smp;
      reset = 1;
      cycles = 0;
      errs = 0;
      req_bus.valid = 0;
      req_bus.sample_left = 0;
      req_bus.sample_mid_left = 0;
      req_bus.sample_middle = 0;
      req_bus.sample_mid_right = 0;
      req_bus.sample_right = 0;
      req_bus.now_ms = 0;
      req_bus.halt = 0;
      csr_bus.valid = 0;
      csr_bus.index = lfpid_pkg::REG_THRESHOLDS;
      csr_bus.data = 0;
      thr_cfg = lfpid_pkg::THR_RESET[49:0];
      light_cfg = 1;
      gp_cfg = lfpid_pkg::GAIN_P_RESET;
      gi_cfg = 0;
      gd_cfg = 0;
      base_cfg = lfpid_pkg::BASE_RESET;
      srch_en_cfg = 1;
      iacc = 0;
      prev_err = 0;
      last_t = 0;
      lost_t0 = 0;
      srch_t0 = 0;
      started = 0;
      lost_on = 0;
      srch_on = 0;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      foreach (DIR_ROWS[k])
         send_frame(DIR_ROWS[k].smp, DIR_ROWS[k].now, DIR_ROWS[k].halt,
                    DIR_ROWS[k].typed, DIR_ROWS[k].exp, 0);

      clk_ms = 10000;
      for (int ph = 0; ph < PHASES; ph++) begin
         drain();
         if (ph > 0) set_phase(ph);
         done = 0;
         while (done < PHASE_LEN) begin
            seg = $urandom_range(0, 9);
            if (seg == 9) begin
               if ($urandom_range(0, 1)) drain();
               smp = rand50();
               send_frame(smp, $urandom(), $urandom_range(0, 1), 0, '0, 0);
               done++;
            end else begin
               len = seg < 6 ? $urandom_range(5, 40) : $urandom_range(10, 70);
               for (int j = 0; j < len; j++) begin
                  want = seg < 6 ? 5'($urandom_range(1, 31)) : 5'd0;
                  for (int i = 0; i < 5; i++) smp[i*10 +: 10] = pick_sample(i, want[i]);
                  clk_ms += seg < 6 ? ms_step() : 32'($urandom_range(10, 120));
                  send_frame(smp, clk_ms, $urandom_range(0, 99) < 2, 0, '0, 0);
                  done++;
               end
            end
         end
      end

      req_bus.valid <= 0;
      while (drive_q.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (errs == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
